// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/kmsr_pkg.sv
`timescale 1ns / 1ps
package kmsr_pkg;

   localparam int KEY_ROWS     = 4;
   localparam int KEY_COLS     = 4;
   localparam int REPORT_SLOTS = 6;

   localparam int KEY_W        = 4;    // 16 matrix positions
   localparam int KEY_LAST     = 15;
   localparam int SLOT_FIELDS  = 6;
   localparam int CODE_W       = 8;
   localparam int MAP_W        = 64;

   localparam logic CSR_KEYMAP_LOW  = 1'b0;
   localparam logic CSR_KEYMAP_HIGH = 1'b1;

   localparam logic [MAP_W-1:0] KEYMAP_LOW_RST  = 64'h0B0A_0908_0706_0504;
   localparam logic [MAP_W-1:0] KEYMAP_HIGH_RST = 64'h1312_1110_0F0E_0D0C;

   typedef logic [CODE_W-1:0] code_type;

   typedef struct packed {
      logic start;     // latch a new scan, rewind the key walk
      logic step;      // process the current key, advance
      logic publish;   // copy the report into the output registers
   } cmd_type;

   typedef struct packed {
      logic last_key;
   } status_type;

   function automatic logic key_in_matrix(input logic [KEY_W-1:0] k);
      return ({1'b0, k[3:2]} < 3'(KEY_ROWS)) && ({1'b0, k[1:0]} < 3'(KEY_COLS));
   endfunction

endpackage

// File: src/kmsr_ctrl.sv
`timescale 1ns / 1ps
module kmsr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kmsr_pkg::status_type status,
   output kmsr_pkg::cmd_type   cmd
);
   import kmsr_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd.start   = 1'b0;
      cmd.step    = 1'b0;
      cmd.publish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.last_key) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.publish) rsp_valid_in = 1'b1;
      else             rsp_valid_in = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/kmsr_datapath.sv
`timescale 1ns / 1ps
module kmsr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  kmsr_pkg::cmd_type    cmd,
   output kmsr_pkg::status_type status,
   input  logic [15:0]          req_keys_pressed,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [63:0]          csr_data,
   output kmsr_pkg::code_type   rsp_slots [kmsr_pkg::SLOT_FIELDS],
   output logic                 rsp_report_changed,
   output logic [15:0]          rsp_held_map
);
   import kmsr_pkg::*;

   logic [MAP_W-1:0] keymap_low_ff, keymap_low_in;
   logic [MAP_W-1:0] keymap_high_ff, keymap_high_in;
   logic [15:0]      scan_ff;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [15:0]      held_ff, held_in;
   logic             changed_ff, changed_in;
   code_type         slots_ff [REPORT_SLOTS];
   code_type         slots_in [REPORT_SLOTS];
   code_type         out_slot_ff [SLOT_FIELDS];
   logic             out_changed_ff;
   logic [15:0]      out_held_ff;

   logic [2*MAP_W-1:0] keymap;
   code_type           code;
   logic               closed, held, press, release_key;
   logic               seen_empty, seen_match;
   logic [REPORT_SLOTS-1:0] put_hit, clr_hit;

   assign status.last_key = (key_ff == KEY_W'(KEY_LAST));

   assign keymap      = {keymap_high_ff, keymap_low_ff};
   assign code        = keymap[{key_ff, 3'b000} +: CODE_W];
   assign closed      = scan_ff[key_ff];
   assign held        = held_ff[key_ff];
   assign press       = key_in_matrix(key_ff) && closed && !held;
   assign release_key = key_in_matrix(key_ff) && !closed && held;

   // first empty slot and first slot holding this code
   always_comb begin
      seen_empty = 1'b0;
      seen_match = 1'b0;
      for (int i = 0; i < REPORT_SLOTS; i++) begin
         put_hit[i] = !seen_empty && (slots_ff[i] == '0);
         clr_hit[i] = !seen_match && (slots_ff[i] == code);
         seen_empty = seen_empty || (slots_ff[i] == '0);
         seen_match = seen_match || (slots_ff[i] == code);
      end
   end

   always_comb begin
      key_in     = key_ff;
      held_in    = held_ff;
      changed_in = changed_ff;
      for (int i = 0; i < REPORT_SLOTS; i++) slots_in[i] = slots_ff[i];
      if (cmd.start) begin
         key_in     = '0;
         changed_in = 1'b0;
      end else if (cmd.step) begin
         key_in = key_ff + 1'b1;
         if (press) begin
            held_in[key_ff] = 1'b1;
            changed_in      = 1'b1;
            for (int i = 0; i < REPORT_SLOTS; i++)
               if (put_hit[i]) slots_in[i] = code;
         end else if (release_key) begin
            held_in[key_ff] = 1'b0;
            changed_in      = 1'b1;
            for (int i = 0; i < REPORT_SLOTS; i++)
               if (clr_hit[i]) slots_in[i] = '0;
         end
      end
   end

   always_comb begin
      keymap_low_in  = keymap_low_ff;
      keymap_high_in = keymap_high_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_KEYMAP_LOW:  keymap_low_in  = csr_data;
            CSR_KEYMAP_HIGH: keymap_high_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keymap_low_ff  <= KEYMAP_LOW_RST;
         keymap_high_ff <= KEYMAP_HIGH_RST;
         key_ff         <= '0;
         held_ff        <= '0;
         changed_ff     <= 1'b0;
         for (int i = 0; i < REPORT_SLOTS; i++) slots_ff[i] <= '0;
      end else begin
         keymap_low_ff  <= keymap_low_in;
         keymap_high_ff <= keymap_high_in;
         key_ff         <= key_in;
         held_ff        <= held_in;
         changed_ff     <= changed_in;
         for (int i = 0; i < REPORT_SLOTS; i++) slots_ff[i] <= slots_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) scan_ff <= req_keys_pressed;
      if (cmd.publish) begin
         out_changed_ff <= changed_ff;
         out_held_ff    <= held_ff;
      end
   end

   for (genvar g = 0; g < SLOT_FIELDS; g++) begin : g_out
      if (g < REPORT_SLOTS) begin : g_shown
         always_ff @(posedge clock) begin
            if (cmd.publish) out_slot_ff[g] <= slots_ff[g];
         end
      end else begin : g_absent
         always_ff @(posedge clock) begin
            if (cmd.publish) out_slot_ff[g] <= '0;
         end
      end
      assign rsp_slots[g] = out_slot_ff[g];
   end

   assign rsp_report_changed = out_changed_ff;
   assign rsp_held_map       = out_held_ff;

endmodule

// File: src/key_matrix_six_slot_report.sv
`timescale 1ns / 1ps
// Six-slot keyboard report builder for a 4x4 key matrix.
// req_ channel: one full matrix scan per request (req_keys_pressed, bit row*4+col).
// rsp_ channel: one report per scan: six keycode slots, a changed flag and the
//   map of keys held after the scan.
// csr_ channel: csr_index 0 writes keymap_low, 1 writes keymap_high (one byte
//   per key, key 0 in the lowest byte); always ready, write only while idle.
// Each scan walks the 16 matrix positions one per cycle through the slot
//   update logic, then publishes the report into the output register;
//   req_ready rises in the same cycle the report becomes valid, and a scan
//   is never accepted while another is being walked.
// The finished report sits in an output register; a new scan may be accepted
//   and walked while it waits. If the receiver stalls, the next report waits
//   after the walk until the output register frees, and req_ready
//   stays low meanwhile.
// Reset (synchronous) clears the held map and all slots, restores the default
//   keymap and drops any pending report.
module key_matrix_six_slot_report (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_keys_pressed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_slot_0,
   output logic [7:0]  rsp_slot_1,
   output logic [7:0]  rsp_slot_2,
   output logic [7:0]  rsp_slot_3,
   output logic [7:0]  rsp_slot_4,
   output logic [7:0]  rsp_slot_5,
   output logic        rsp_report_changed,
   output logic [15:0] rsp_held_map,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   import kmsr_pkg::*;

   cmd_type    cmd;
   status_type status;
   code_type   slots [SLOT_FIELDS];

   assign csr_ready = 1'b1;

   kmsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kmsr_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_keys_pressed   (req_keys_pressed),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_slots          (slots),
      .rsp_report_changed (rsp_report_changed),
      .rsp_held_map       (rsp_held_map)
   );

   assign rsp_slot_0 = slots[0];
   assign rsp_slot_1 = slots[1];
   assign rsp_slot_2 = slots[2];
   assign rsp_slot_3 = slots[3];
   assign rsp_slot_4 = slots[4];
   assign rsp_slot_5 = slots[5];

endmodule

// File: src/kmsr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kmsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_slot_0,
   input logic [7:0]  rsp_slot_1,
   input logic [7:0]  rsp_slot_2,
   input logic [7:0]  rsp_slot_3,
   input logic [7:0]  rsp_slot_4,
   input logic [7:0]  rsp_slot_5,
   input logic        rsp_report_changed,
   input logic [15:0] rsp_held_map
);

   // a scan in flight blocks the next request
   `ASSERT_CLK(a_busy_after_req, clock, reset, (req_valid && req_ready) |=> !req_ready, "request accepted while busy")

   // the key walk lies between request and report; no report can appear right after a request
   `ASSERT_CLK(a_no_early_rsp, clock, reset, (req_valid && req_ready) |=> !$rose(rsp_valid), "report too early")

   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_held_map) && $stable(rsp_slot_0) && $stable(rsp_slot_1) && $stable(rsp_slot_2) && $stable(rsp_slot_3) && $stable(rsp_slot_4) && $stable(rsp_slot_5) && $stable(rsp_report_changed)), "stalled report changed")

   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && req_ready), "reset left a report pending")

endmodule

bind key_matrix_six_slot_report kmsr_checker u_kmsr_checker (.*);
